@@ rtl/core/gregorian_date_add_days_defines.svh @@
// Assertion macros for the Gregorian date adder.
// Used by the top level only; empty when SYNTH is defined.
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

`ifndef SYNTH
`define GDAD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gdad assertion failed");
`define GDAD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gdad assertion failed");
`else
`define GDAD_ASSERT_IMP(label, clk, rst, ante, cons)
`define GDAD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/gdad_pkg.sv @@
// Shared types, constants and month-length function for the date adder.
// No dependencies.
package gdad_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int AddW    = 15;
  localparam int RemW    = 16;
  localparam int QuotW   = 8;

  // floor(y / 100) = (y * RecipHundred) >> RecipShift for all 14-bit y
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int          RecipShift   = 19;
  localparam logic [YearW-1:0] Hundred = 14'd100;

  localparam logic [MonthW-1:0] January  = 4'd1;
  localparam logic [MonthW-1:0] February = 4'd2;
  localparam logic [MonthW-1:0] December = 4'd12;

  localparam logic [DayW-1:0] MonthLenCommon [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [DayW-1:0] FebLeap = 5'd29;

  typedef struct packed {
    logic [YearW-1:0]  start_year;
    logic [MonthW-1:0] start_month;
    logic [DayW-1:0]   start_day;
    logic [AddW-1:0]   days_to_add;
  } req_t;

  typedef struct packed {
    logic [YearW-1:0]  result_year;
    logic [MonthW-1:0] result_month;
    logic [DayW-1:0]   result_day;
    logic              input_error;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic req_err;
    logic fits;
  } stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = 5'd0;
    if (m >= January && m <= December) begin
      if (m == February && leap) begin
        len = FebLeap;
      end else begin
        len = MonthLenCommon[m - January];
      end
    end
    return len;
  endfunction

endpackage

@@ rtl/core/gdad_dp.sv @@
// Datapath of the date adder: year, month and remaining-day registers,
// leap-year unit and result register. Depends on gdad_pkg.
module gdad_dp (
  input  logic          clk,
  input  gdad_pkg::req_t req,
  input  gdad_pkg::cmd_t cmd,
  output gdad_pkg::stat_t stat,
  output gdad_pkg::rsp_t rsp
);
  import gdad_pkg::*;

  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [RemW-1:0]   remaining;
  logic              err;
  logic [QuotW-1:0]  quot;
  logic [26:0]       prod;
  logic [YearW-1:0]  hund;
  logic              leap;
  logic [DayW-1:0]   len;
  rsp_t              rsp_reg;

  // Quotient of the year by one hundred, registered from the year register.
  assign prod = {13'd0, year} * {14'd0, RecipHundred};
  assign hund = YearW'({6'd0, quot} * Hundred);
  assign leap = (year[1:0] == 2'b00) && ((year != hund) || (quot[1:0] == 2'b00));
  assign len  = month_len(month, leap);

  assign stat.req_err = (req.start_month < January) || (req.start_month > December) ||
                        (req.start_day == '0);
  assign stat.fits    = remaining <= {{(RemW-DayW){1'b0}}, len};

  always_ff @(posedge clk) begin
    quot <= prod[RecipShift +: QuotW];
    if (cmd.load) begin
      year      <= req.start_year;
      month     <= req.start_month;
      remaining <= {{(RemW-DayW){1'b0}}, req.start_day} +
                   {{(RemW-AddW){1'b0}}, req.days_to_add};
      err       <= stat.req_err;
    end else if (cmd.step) begin
      remaining <= remaining - {{(RemW-DayW){1'b0}}, len};
      if (month == December) begin
        month <= January;
        year  <= year + 1'b1;
      end else begin
        month <= month + 1'b1;
      end
    end
    if (cmd.write_out) begin
      if (err) begin
        rsp_reg <= '{result_year: '0, result_month: '0, result_day: '0, input_error: 1'b1};
      end else begin
        rsp_reg <= '{result_year: year, result_month: month,
                     result_day: remaining[DayW-1:0], input_error: 1'b0};
      end
    end
  end

  assign rsp = rsp_reg;

endmodule

@@ rtl/core/gdad_ctrl.sv @@
// Controller of the date adder: request handshake, walk sequencing and
// response valid. Depends on gdad_pkg.
module gdad_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  gdad_pkg::stat_t stat,
  output gdad_pkg::cmd_t  cmd
);
  import gdad_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPrep = 2'd1;
  localparam logic [1:0] StWalk = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state, state_next;
  logic       rsp_valid_reg, rsp_valid_next;
  logic       slot_free;

  assign req_stall = state != StIdle;
  assign slot_free = !rsp_valid_reg || !rsp_stall;

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.step      = 1'b0;
    cmd.write_out = 1'b0;
    unique case (state)
      StIdle: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.req_err ? StDone : StPrep;
        end
      end
      // let the year quotient settle for the loaded year
      StPrep: state_next = StWalk;
      StWalk: begin
        if (stat.fits) begin
          state_next = StDone;
        end else begin
          cmd.step = 1'b1;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd.write_out = 1'b1;
          state_next    = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_comb begin
    priority if (cmd.write_out) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= StIdle;
      rsp_valid_reg <= 1'b0;
    end else begin
      state         <= state_next;
      rsp_valid_reg <= rsp_valid_next;
    end
  end

  assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/core/gregorian_date_add_days.sv @@
// Gregorian date plus a day count. A request carries a start date and a count
// of days; the response carries the date that many days later, or an error
// flag with a zero date when the month is outside 1..12 or the day is zero.
// A day past the end of its month is not flagged and simply counts on. One
// request is worked at a time: load, a step to settle the leap-year unit,
// then one walk step per month boundary crossed from the start month, then
// the write of the response register once its slot is free. An erroneous
// request skips the settle and walk steps. The month walk, which subtracts
// one month length per cycle, takes most of the time. The response
// register lets a new request be taken while the previous response still
// waits.
// Depends on gdad_pkg, gdad_dp, gdad_ctrl and the assertion macro header.
`include "gregorian_date_add_days_defines.svh"

module gregorian_date_add_days (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  gdad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output gdad_pkg::rsp_t rsp
);
  import gdad_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: takes the request, steps the walk, writes the response.
  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: holds the running date and the days still to place.
  gdad_dp u_dp (
    .clk  (clk),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

  // Hold off further requests once one is taken.
  `GDAD_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  // Drop the date on an erroneous request.
  `GDAD_ASSERT_IMP(a_err_zero, clk, rst, rsp_valid && rsp.input_error, rsp.result_year == '0 && rsp.result_month == '0 && rsp.result_day == '0)
  // A good response names a real month and a non-zero day.
  `GDAD_ASSERT_IMP(a_good_date, clk, rst, rsp_valid && !rsp.input_error, rsp.result_month >= January && rsp.result_month <= December && rsp.result_day != '0)

endmodule
